>>> rtl/afgr_pkg.sv
`timescale 1ns / 1ps
package afgr_pkg;

    localparam int unsigned STATION_ADDRESS_RESET = 1;
    localparam int unsigned GAP_TICKS_RESET       = 5;
    localparam int unsigned HEARTBEAT_LIMIT_RESET = 500;
    localparam int unsigned POLL_PERIOD_RESET     = 50;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DATA_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATION_ADDRESS = 2'd0,
        CFG_GAP_TICKS       = 2'd1,
        CFG_HEARTBEAT_LIMIT = 2'd2,
        CFG_POLL_PERIOD     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_BYTE = 2'd1,
        OP_ACK  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_in_item;

    typedef struct packed {
        logic              frame_ready;
        logic [DATA_W-1:0] frame_data;
        logic              receiver_restart;
        logic              heartbeat_led;
        logic              poll_event;
    } t_out_item;

endpackage

>>> rtl/afgr_if.sv
`timescale 1ns / 1ps
interface afgr_in_if;
    logic                valid;
    logic                ready;
    afgr_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface afgr_out_if;
    logic                valid;
    logic                ready;
    afgr_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/addressed_frame_gap_receiver.sv
`timescale 1ns / 1ps
// latency: a result beat appears in the cycle after its input beat is taken
// throughput: one beat per cycle while o_res.ready holds; the single output register frees as it is taken
// reset (synchronous, active low): counters, flags and led clear, registers take
// their default values, the frame buffer itself is left as it was
module addressed_frame_gap_receiver #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [afgr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [afgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    afgr_in_if.sink                             i_in,
    afgr_out_if.source                          o_res
);

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int unsigned IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BYTES);

    // configuration
    logic [7:0]  r_station_address;
    logic [7:0]  r_gap_ticks;
    logic [15:0] r_heartbeat_limit;
    logic [7:0]  r_poll_period;

    // receive state
    logic [7:0]       r_buf [FRAME_BYTES];
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_gap_counter, n_gap_counter;
    logic             r_ready_flag, n_ready_flag;
    logic [15:0]      r_heartbeat_count, n_heartbeat_count;
    logic             r_led_level, n_led_level;
    logic [7:0]       r_poll_count, n_poll_count;

    // output stage
    logic                r_out_valid;
    afgr_pkg::t_out_item r_out, n_out;

    logic             accept;
    logic             buf_we;
    logic [IDX_W-1:0] buf_idx;
    logic [7:0]       byte0;
    logic [7:0]       gap_dec;
    logic [15:0]      hb_inc;
    logic [7:0]       poll_inc;
    logic             restart;
    logic             poll;
    logic [afgr_pkg::DATA_W-1:0] packed_frame;

    assign i_in.ready    = !r_out_valid || o_res.ready;
    assign accept        = i_in.valid && i_in.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= 8'(afgr_pkg::STATION_ADDRESS_RESET);
            r_gap_ticks       <= 8'(afgr_pkg::GAP_TICKS_RESET);
            r_heartbeat_limit <= 16'(afgr_pkg::HEARTBEAT_LIMIT_RESET);
            r_poll_period     <= 8'(afgr_pkg::POLL_PERIOD_RESET);
        end else if (i_cfg_we) begin
            unique case (afgr_pkg::t_cfg_idx'(i_cfg_idx))
                afgr_pkg::CFG_STATION_ADDRESS: r_station_address <= i_cfg_data[7:0];
                afgr_pkg::CFG_GAP_TICKS:       r_gap_ticks       <= i_cfg_data[7:0];
                afgr_pkg::CFG_HEARTBEAT_LIMIT: r_heartbeat_limit <= i_cfg_data;
                afgr_pkg::CFG_POLL_PERIOD:     r_poll_period     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign buf_idx = r_byte_count[IDX_W-1:0];
    // byte 0 as it stands after this beat's write
    assign byte0   = (buf_idx == '0) ? i_in.payload.rx_byte : r_buf[0];
    assign gap_dec = r_gap_counter - 8'd1;
    assign hb_inc  = r_heartbeat_count + 16'd1;
    assign poll_inc = r_poll_count + 8'd1;

    always_comb begin
        n_byte_count      = r_byte_count;
        n_gap_counter     = r_gap_counter;
        n_ready_flag      = r_ready_flag;
        n_heartbeat_count = r_heartbeat_count;
        n_led_level       = r_led_level;
        n_poll_count      = r_poll_count;
        buf_we            = 1'b0;
        restart           = 1'b0;
        poll              = 1'b0;
        unique case (afgr_pkg::t_op'(i_in.payload.op))
            afgr_pkg::OP_TICK: begin
                n_heartbeat_count = hb_inc;
                if (hb_inc > r_heartbeat_limit) begin
                    n_heartbeat_count = '0;
                    n_led_level       = !r_led_level;
                end
                n_poll_count = poll_inc;
                if (poll_inc >= r_poll_period) begin
                    n_poll_count = '0;
                    poll         = 1'b1;
                end
                if (r_gap_counter != '0) begin
                    n_gap_counter = gap_dec;
                    if (gap_dec == '0) begin
                        if (r_byte_count == FULL_COUNT) begin
                            n_ready_flag = 1'b1;
                        end else begin
                            restart      = i_in.payload.rx_error;
                            n_byte_count = '0;
                        end
                    end
                end
            end
            afgr_pkg::OP_BYTE: begin
                n_gap_counter = r_gap_ticks;
                if (r_byte_count < FULL_COUNT && !r_ready_flag) begin
                    buf_we = 1'b1;
                    if (byte0 == r_station_address) begin
                        n_byte_count = r_byte_count + CNT_W'(1);
                    end
                end
            end
            afgr_pkg::OP_ACK: begin
                n_ready_flag = 1'b0;
                n_byte_count = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && buf_we) begin
            r_buf[buf_idx] <= i_in.payload.rx_byte;
        end
    end

    // frame seen after this beat; unused high bytes stay zero
    always_comb begin
        packed_frame = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (buf_we && buf_idx == IDX_W'(i)) begin
                packed_frame[8*i +: 8] = i_in.payload.rx_byte;
            end else begin
                packed_frame[8*i +: 8] = r_buf[i];
            end
        end
    end

    always_comb begin
        n_out.frame_ready      = n_ready_flag;
        n_out.frame_data       = n_ready_flag ? packed_frame : '0;
        n_out.receiver_restart = restart;
        n_out.heartbeat_led    = n_led_level;
        n_out.poll_event       = poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count      <= '0;
            r_gap_counter     <= '0;
            r_ready_flag      <= 1'b0;
            r_heartbeat_count <= '0;
            r_led_level       <= 1'b0;
            r_poll_count      <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (accept) begin
                r_byte_count      <= n_byte_count;
                r_gap_counter     <= n_gap_counter;
                r_ready_flag      <= n_ready_flag;
                r_heartbeat_count <= n_heartbeat_count;
                r_led_level       <= n_led_level;
                r_poll_count      <= n_poll_count;
                r_out_valid       <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_ready_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_flag |-> r_byte_count == FULL_COUNT)
        else $error("frame ready without a full byte count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= FULL_COUNT)
        else $error("byte count beyond frame length");

    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.payload.op == afgr_pkg::OP_ACK |=> !r_ready_flag && r_byte_count == '0)
        else $error("acknowledge did not clear the frame");

    a_restart_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.receiver_restart |-> !r_out.frame_ready)
        else $error("restart beat with a frame held");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import afgr_pkg::*;

    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  OP_SPARE    = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    afgr_in_if  in_if ();
    afgr_out_if res_if ();

    addressed_frame_gap_receiver #(
        .FRAME_BYTES (FRAME_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    always #1 i_clk = ~i_clk;

    // receiver state as the block should hold it
    logic [7:0]  rx_store [FRAME_LEN] = '{default: 8'h00};
    logic [3:0]  held_count   = '0;
    logic [7:0]  gap_left     = '0;
    logic        frame_held   = 1'b0;
    logic [15:0] beat_ticks   = '0;
    logic        led_on       = 1'b0;
    logic [7:0]  poll_ticks   = '0;
    logic [7:0]  station_addr = 8'(STATION_ADDRESS_RESET);
    logic [7:0]  gap_reload   = 8'(GAP_TICKS_RESET);
    logic [15:0] beat_limit   = 16'(HEARTBEAT_LIMIT_RESET);
    logic [7:0]  poll_len     = 8'(POLL_PERIOD_RESET);

    t_in_item    event_backlog[$];
    t_out_item   expected_status_q[$];
    logic        in_taken = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    function automatic t_out_item predict_status(input t_in_item ev);
        t_out_item r;
        r = '0;
        case (ev.op)
            OP_TICK: begin
                beat_ticks = beat_ticks + 16'd1;
                if (beat_ticks > beat_limit) begin
                    beat_ticks = '0;
                    led_on     = !led_on;
                end
                poll_ticks = poll_ticks + 8'd1;
                if (poll_ticks >= poll_len) begin
                    poll_ticks   = '0;
                    r.poll_event = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left = gap_left - 8'd1;
                    if (gap_left == 0) begin
                        if (held_count == FRAME_LEN) begin
                            frame_held = 1'b1;
                        end else begin
                            r.receiver_restart = ev.rx_error;
                            held_count         = '0;
                        end
                    end
                end
            end
            OP_BYTE: begin
                gap_left = gap_reload;
                if (held_count < FRAME_LEN && !frame_held) begin
                    rx_store[held_count[2:0]] = ev.rx_byte;
                    // the count only moves once the first byte names this station
                    if (rx_store[0] == station_addr)
                        held_count = held_count + 4'd1;
                end
            end
            OP_ACK: begin
                frame_held = 1'b0;
                held_count = '0;
            end
            default: begin
            end
        endcase
        r.frame_ready   = frame_held;
        r.heartbeat_led = led_on;
        if (frame_held) begin
            for (int i = 0; i < FRAME_LEN; i++)
                r.frame_data[8*i +: 8] = rx_store[i];
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // monitor: checks result beats, then predicts for the input beat of this edge
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STATION_ADDRESS: station_addr = i_cfg_data[7:0];
                    CFG_GAP_TICKS:       gap_reload   = i_cfg_data[7:0];
                    CFG_HEARTBEAT_LIMIT: beat_limit   = i_cfg_data;
                    CFG_POLL_PERIOD:     poll_len     = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (expected_status_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    note_mismatch("frame_ready", 64'(want.frame_ready), 64'(got.frame_ready));
                    note_mismatch("frame_data", want.frame_data, got.frame_data);
                    note_mismatch("receiver_restart", 64'(want.receiver_restart),
                                  64'(got.receiver_restart));
                    note_mismatch("heartbeat_led", 64'(want.heartbeat_led),
                                  64'(got.heartbeat_led));
                    note_mismatch("poll_event", 64'(want.poll_event), 64'(got.poll_event));
                end
            end
            if (in_if.valid && in_if.ready)
                expected_status_q.push_back(predict_status(in_if.payload));
            in_taken <= in_if.valid && in_if.ready;
        end
    end

    // driver: a beat stays up until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (event_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.payload <= event_backlog.pop_front();
                in_if.valid   <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void push_event(input logic [1:0] op, input logic [7:0] b,
                                       input logic e);
        t_in_item it;
        it.op       = op;
        it.rx_byte  = b;
        it.rx_error = e;
        event_backlog.push_back(it);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // unused upper bits of the narrow registers get noise
    task automatic apply_setting(input logic [7:0] addr, input logic [7:0] gap,
                                 input logic [15:0] limit, input logic [7:0] poll);
        write_reg(CFG_STATION_ADDRESS, {8'($urandom), addr});
        write_reg(CFG_GAP_TICKS, {8'($urandom), gap});
        write_reg(CFG_HEARTBEAT_LIMIT, limit);
        write_reg(CFG_POLL_PERIOD, {8'($urandom), poll});
    endtask

    task automatic settle();
        while (event_backlog.size() != 0 || in_if.valid || expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly whole frames closed by a gap, with short or misaddressed frames and noise
    task automatic queue_traffic(input int unsigned n, input logic [7:0] addr,
                                 input logic [7:0] gap);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int unsigned gap_run;
        int i;
        start = event_backlog.size();
        while (event_backlog.size() - start < n) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = (pick < 60) ? FRAME_LEN : $urandom_range(FRAME_LEN - 1, 1);
                for (i = 0; i < len; i++) begin
                    if (i == 0 && (pick < 60 || $urandom_range(1) == 0))
                        push_event(OP_BYTE, addr, 1'($urandom));
                    else
                        push_event(OP_BYTE, 8'($urandom), 1'($urandom));
                end
                gap_run = (gap == 0) ? $urandom_range(4, 1) : gap + $urandom_range(2);
                for (i = 0; i < gap_run; i++)
                    push_event(OP_TICK, 8'($urandom), 1'($urandom));
                if ($urandom_range(3) != 0)
                    push_event(OP_ACK, 8'($urandom), 1'($urandom));
            end else begin
                push_event(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_STATION_ADDRESS;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        res_if.ready  = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 79;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short gap, quick heartbeat, poll on every tick
        apply_setting(8'hA5, 8'd2, 16'd3, 8'd0);
        push_event(OP_ACK, 8'h00, 1'b0);        // acknowledge with nothing held
        push_event(OP_SPARE, 8'hFF, 1'b1);
        push_event(OP_TICK, 8'h00, 1'b0);
        push_event(OP_BYTE, 8'h00, 1'b0);       // wrong station
        push_event(OP_TICK, 8'h00, 1'b1);
        push_event(OP_TICK, 8'h00, 1'b1);       // short frame with error: restart
        push_event(OP_BYTE, 8'hA5, 1'b0);
        push_event(OP_BYTE, 8'hFF, 1'b1);
        push_event(OP_BYTE, 8'h00, 1'b0);
        push_event(OP_BYTE, 8'h55, 1'b0);
        push_event(OP_BYTE, 8'hAA, 1'b1);
        push_event(OP_BYTE, 8'h01, 1'b0);
        push_event(OP_BYTE, 8'h80, 1'b0);
        push_event(OP_BYTE, 8'h7F, 1'b0);
        push_event(OP_BYTE, 8'h12, 1'b0);       // ninth byte only reloads the gap
        push_event(OP_TICK, 8'h00, 1'b1);
        push_event(OP_TICK, 8'h00, 1'b1);       // full frame: ready, no restart
        push_event(OP_BYTE, 8'h34, 1'b0);       // not stored while a frame is held; it only reloads the gap
        push_event(OP_SPARE, 8'h00, 1'b0);
        push_event(OP_TICK, 8'hFF, 1'b0);
        push_event(OP_TICK, 8'hFF, 1'b0);
        push_event(OP_ACK, 8'hFF, 1'b1);
        push_event(OP_BYTE, 8'hA5, 1'b1);
        push_event(OP_TICK, 8'h00, 1'b0);
        push_event(OP_TICK, 8'h00, 1'b0);       // short frame, no error
        settle();

        apply_setting(8'h01, 8'd1, 16'd1, 8'd1);
        queue_traffic(120, 8'h01, 8'd1);
        settle();

        send_idle_pct = 79;
        recv_idle_pct = 25;
        begin
            logic [7:0] addr;
            addr = 8'($urandom);
            apply_setting(addr, 8'd4, 16'd9, 8'd7);
            queue_traffic(120, addr, 8'd4);
        end
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(8'hFF, 8'd255, 16'hFFFF, 8'd255);
        queue_traffic(100, 8'hFF, 8'd255);
        settle();

        // gap timer never runs out
        apply_setting(8'h00, 8'd0, 16'hFFFF, 8'd0);
        queue_traffic(50, 8'h00, 8'd0);
        repeat (30) push_event(OP_TICK, 8'($urandom), 1'($urandom));
        settle();

        begin
            logic [7:0] addr;
            addr = 8'($urandom);
            apply_setting(addr, 8'd6, 16'd20, 8'd3);
            queue_traffic(100, addr, 8'd6);
        end
        settle();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
